// ===== rtl/bounded_neighbor_list_assert.svh =====
// assertion macros shared by the neighbor list rtl
`ifndef BOUNDED_NEIGHBOR_LIST_ASSERT_SVH
`define BOUNDED_NEIGHBOR_LIST_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define BNL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("neighbor list check failed");

// next-cycle implication, disabled while reset is held
`define BNL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("neighbor list check failed");

`endif

// ===== rtl/bnl_pkg.sv =====
// shared widths, request and status codes and cell control type
package bnl_pkg;

    localparam int REQ_W      = 3;
    localparam int NODE_ID_W  = 16;
    localparam int INDEX_W    = 4;
    localparam int STATUS_W   = 3;
    localparam int LINK_W     = 5;
    localparam int OWN_ID_W   = 16;
    localparam int LIMIT_W    = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    // compare width for positions, counts and limits (capacity up to 511)
    localparam int CMP_W      = 9;

    typedef logic [REQ_W-1:0]    t_req;
    typedef logic [STATUS_W-1:0] t_status;

    // request codes
    localparam t_req REQ_ADD         = 3'd0;
    localparam t_req REQ_REMOVE_ID   = 3'd1;
    localparam t_req REQ_REMOVE_AT   = 3'd2;
    localparam t_req REQ_REMOVE_LAST = 3'd3;
    localparam t_req REQ_READ        = 3'd4;

    // status codes
    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_OWN      = 3'd1;
    localparam t_status ST_PRESENT  = 3'd2;
    localparam t_status ST_NOTFOUND = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ID     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LINK_LIMIT = 2'd1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // per-request control broadcast to every cell
    typedef struct packed {
        logic               append;
        logic               rm_id;
        logic               rm_at;
        logic [INDEX_W-1:0] index;
    } t_cell_ctl;

endpackage

// ===== rtl/bnl_req_if.sv =====
// request channel: valid, ready and request word
interface bnl_req_if;
    import bnl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [NODE_ID_W-1:0] node_id;
    logic [INDEX_W-1:0]   index;

    modport source (output valid, output req_type, output node_id, output index,
                    input ready);
    modport sink   (input valid, input req_type, input node_id, input index,
                    output ready);
endinterface

// ===== rtl/bnl_rsp_if.sv =====
// response channel: valid, ready and result word
interface bnl_rsp_if;
    import bnl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [NODE_ID_W-1:0] read_id;
    logic [LINK_W-1:0]    link_count;

    modport source (output valid, output status, output read_id, output link_count,
                    input ready);
    modport sink   (input valid, input status, input read_id, input link_count,
                    output ready);
endinterface

// ===== rtl/bnl_cell.sv =====
// one list slot: holds an entry, matches it, shifts down or appends
module bnl_cell #(
    parameter int IDX     = 0,
    parameter int ID_BITS = 16,
    parameter int CNT_W   = 5
) (
    input  logic                   i_clk,
    input  bnl_pkg::t_cell_ctl     i_ctl,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [ID_BITS-1:0]     i_id,
    input  logic [ID_BITS-1:0]     i_next_entry,
    input  logic                   i_hit,
    output logic                   o_hit,
    input  logic [ID_BITS-1:0]     i_rd,
    output logic [ID_BITS-1:0]     o_rd,
    output logic [ID_BITS-1:0]     o_entry
);
    import bnl_pkg::*;

    localparam logic [CMP_W-1:0] POS = CMP_W'(IDX);

    logic [ID_BITS-1:0] r_entry;
    logic [ID_BITS-1:0] n_entry;
    logic [CMP_W-1:0]   w_count;
    logic [CMP_W-1:0]   w_index;
    logic               w_occ;
    logic               w_match;
    logic               w_hit;
    logic               w_sel;
    logic               w_shift;
    logic               w_load;

    assign w_count = CMP_W'(i_count);
    assign w_index = CMP_W'(i_ctl.index);

    // match only on occupied slots, hit ripples toward the tail
    assign w_occ   = POS < w_count;
    assign w_match = w_occ && (r_entry == i_id);
    assign w_hit   = i_hit | w_match;
    assign o_hit   = w_hit;

    // read path: selected slot ors its entry into the chain
    assign w_sel = POS == w_index;
    assign o_rd  = i_rd | (w_sel ? r_entry : '0);

    // slots at and after the removed one take their neighbor's entry
    assign w_shift = (i_ctl.rm_id && w_hit) || (i_ctl.rm_at && (POS >= w_index));
    assign w_load  = i_ctl.append && (POS == w_count);

    always_comb begin
        priority if (w_load) begin
            n_entry = i_id;
        end else if (w_shift) begin
            n_entry = i_next_entry;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/bounded_neighbor_list.sv =====
// bounded neighbor list: ordered id list with duplicate and own-id checks
//
// Requests arrive on i_req (req_type, node_id, index) with a valid/ready
// handshake; each request gives exactly one word on o_rsp (status, read_id,
// link_count). Configuration (own id, link limit) is written through the
// plain write port i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce;
// indexes past the register list are ignored. An accepted request is latched,
// then in the execute state it runs through the cell row (compare, hit ripple,
// shift or append) and loads the output register. One request is in work at a
// time: no new request is accepted until the current one has executed. The hit
// ripple across the cell row sets the length of the execute path.
// The output register holds a finished word while the receiver stalls; a new
// request is still accepted meanwhile, and its execution waits until the
// held word is taken.
// Reset (synchronous, active low) empties the list, sets own id to zero and
// the link limit to 16; entry contents are not cleared.
`include "bounded_neighbor_list_assert.svh"

module bounded_neighbor_list #(
    parameter int CAPACITY = 16,
    parameter int ID_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bnl_pkg::CFG_ADDR_W-1:0] i_cfg_idx,
    input  logic [bnl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bnl_req_if.sink                       i_req,
    bnl_rsp_if.source                     o_rsp
);
    import bnl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 r_state;
    logic                 n_state;
    logic [OWN_ID_W-1:0]  r_own_id;
    logic [LIMIT_W-1:0]   r_limit;
    t_req                 r_req;
    logic [ID_BITS-1:0]   r_id;
    logic [INDEX_W-1:0]   r_index;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_status              r_status;
    t_status              n_status;
    logic [NODE_ID_W-1:0] r_read_id;
    logic [NODE_ID_W-1:0] n_read_id;
    logic [LINK_W-1:0]    r_link_count;

    logic                 w_accept;
    logic                 w_go;
    logic [CMP_W-1:0]     w_limit;
    logic [CMP_W-1:0]     w_eff_limit;
    logic [CMP_W-1:0]     w_cnt;
    logic                 w_full;
    logic                 w_own;
    logic                 w_idx_ok;
    logic                 w_any_hit;
    logic                 w_append;
    logic                 w_rm_id;
    logic                 w_rm_at;
    logic                 w_do_read;
    logic [CNT_W-1:0]     w_count_d;
    t_cell_ctl            w_ctl;

    logic [ID_BITS-1:0]   w_entry [CAPACITY+1];
    logic                 w_hit   [CAPACITY+1];
    logic [ID_BITS-1:0]   w_rd    [CAPACITY+1];

    // handshake and sequencing
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_go        = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (w_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // checks on the latched request
    assign w_limit     = CMP_W'(r_limit);
    assign w_eff_limit = (w_limit > CAP_C) ? CAP_C : w_limit;
    assign w_cnt       = CMP_W'(r_count);
    assign w_full      = w_cnt >= w_eff_limit;
    assign w_own       = r_id == ID_BITS'(r_own_id);
    assign w_idx_ok    = CMP_W'(r_index) < w_cnt;
    assign w_any_hit   = w_hit[CAPACITY];

    // request decode
    always_comb begin
        n_status  = ST_NOTFOUND;
        w_count_d = r_count;
        w_append  = 1'b0;
        w_rm_id   = 1'b0;
        w_rm_at   = 1'b0;
        w_do_read = 1'b0;
        unique case (r_req)
            REQ_ADD: begin
                priority if (w_full) begin
                    n_status = ST_FULL;
                end else if (w_own) begin
                    n_status = ST_OWN;
                end else if (w_any_hit) begin
                    n_status = ST_PRESENT;
                end else begin
                    n_status  = ST_OK;
                    w_append  = 1'b1;
                    w_count_d = r_count + CNT_W'(1);
                end
            end
            REQ_REMOVE_ID: begin
                if (w_any_hit) begin
                    n_status  = ST_OK;
                    w_rm_id   = 1'b1;
                    w_count_d = r_count - CNT_W'(1);
                end
            end
            REQ_REMOVE_AT: begin
                if (w_idx_ok) begin
                    n_status  = ST_OK;
                    w_rm_at   = 1'b1;
                    w_count_d = r_count - CNT_W'(1);
                end
            end
            REQ_REMOVE_LAST: begin
                if (r_count != '0) begin
                    n_status  = ST_OK;
                    w_count_d = r_count - CNT_W'(1);
                end
            end
            REQ_READ: begin
                if (w_idx_ok) begin
                    n_status  = ST_OK;
                    w_do_read = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // control word for the cell row, gated by execute
    assign w_ctl.append = w_go && w_append;
    assign w_ctl.rm_id  = w_go && w_rm_id;
    assign w_ctl.rm_at  = w_go && w_rm_at;
    assign w_ctl.index  = r_index;

    assign n_count   = w_go ? w_count_d : r_count;
    assign n_read_id = w_do_read ? NODE_ID_W'(w_rd[CAPACITY]) : '0;

    // output register
    always_comb begin
        priority if (w_go) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // cell row
    assign w_hit[0] = 1'b0;
    assign w_rd[0]  = '0;
    assign w_entry[CAPACITY] = w_entry[CAPACITY-1];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bnl_cell #(
            .IDX     (g),
            .ID_BITS (ID_BITS),
            .CNT_W   (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_id         (r_id),
            .i_next_entry (w_entry[g+1]),
            .i_hit        (w_hit[g]),
            .o_hit        (w_hit[g+1]),
            .i_rd         (w_rd[g]),
            .o_rd         (w_rd[g+1]),
            .o_entry      (w_entry[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_own_id    <= '0;
            r_limit     <= LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && (i_cfg_idx == CFG_OWN_ID)) begin
                r_own_id <= OWN_ID_W'(i_cfg_data);
            end
            if (i_cfg_we && (i_cfg_idx == CFG_LINK_LIMIT)) begin
                r_limit <= LIMIT_W'(i_cfg_data);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req.req_type;
            r_id    <= ID_BITS'(i_req.node_id);
            r_index <= i_req.index;
        end
        if (w_go) begin
            r_status     <= n_status;
            r_read_id    <= n_read_id;
            r_link_count <= LINK_W'(w_count_d);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_id    = r_read_id;
    assign o_rsp.link_count = r_link_count;

    // a fresh response word only follows an execute cycle
    `BNL_ASSERT_NOW(a_out_from_exec, i_clk, i_rst_n, o_rsp.valid && !$past(o_rsp.valid), $past(r_state == ST_EXEC))
    // a rejected request leaves the count as it was
    `BNL_ASSERT_NEXT(a_reject_keeps_count, i_clk, i_rst_n, w_go && (n_status != ST_OK), r_count == $past(r_count))
    // the count never passes the capacity after an execute
    `BNL_ASSERT_NEXT(a_count_bounded, i_clk, i_rst_n, w_go, CMP_W'(r_count) <= CAP_C)

endmodule

// ===== sim/neighbor_list_checker.sv =====
// checker for the bounded neighbor list: predicts each reply word and compares it
`timescale 1ns / 100ps

module neighbor_list_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bnl_pkg::CFG_ADDR_W-1:0] i_cfg_idx,
    input  logic [bnl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bnl_req_if                             i_req,
    bnl_rsp_if                             i_rsp,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bnl_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        t_status              status;
        logic [NODE_ID_W-1:0] read_id;
        logic [LINK_W-1:0]    link_count;
    } t_reply;

    // shadow copy of the list and its registers
    logic [OWN_ID_W-1:0]  own_id_q;
    logic [LIMIT_W-1:0]   limit_q;
    logic [NODE_ID_W-1:0] neighbors [SLOTS];
    int unsigned          fill;

    // replies owed by the block, oldest first
    t_reply awaited_replies [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // position of the first entry holding id, -1 when absent
    function automatic int locate(logic [NODE_ID_W-1:0] id);
        for (int i = 0; i < int'(fill); i++) begin
            if (neighbors[i] == id) return i;
        end
        return -1;
    endfunction

    // drop one entry and pull the tail forward
    function automatic void close_gap(int pos);
        for (int i = pos; i + 1 < int'(fill); i++) begin
            neighbors[i] = neighbors[i + 1];
        end
        fill--;
    endfunction

    // apply one request to the shadow list and build the reply it earns
    function automatic t_reply serve_request(t_req kind, logic [NODE_ID_W-1:0] id,
                                             logic [INDEX_W-1:0] ix);
        t_reply      r;
        int          pos;
        int unsigned cap;
        r.status  = ST_NOTFOUND;
        r.read_id = '0;
        cap = (limit_q > SLOTS) ? SLOTS : limit_q;
        case (kind)
            REQ_ADD: begin
                // full wins over own id, own id over already present
                if (fill >= cap) begin
                    r.status = ST_FULL;
                end else if (id == own_id_q) begin
                    r.status = ST_OWN;
                end else if (locate(id) >= 0) begin
                    r.status = ST_PRESENT;
                end else begin
                    neighbors[fill] = id;
                    fill++;
                    r.status = ST_OK;
                end
            end
            REQ_REMOVE_ID: begin
                pos = locate(id);
                if (pos >= 0) begin
                    close_gap(pos);
                    r.status = ST_OK;
                end
            end
            REQ_REMOVE_AT: begin
                if (ix < fill) begin
                    close_gap(int'(ix));
                    r.status = ST_OK;
                end
            end
            REQ_REMOVE_LAST: begin
                if (fill > 0) begin
                    fill--;
                    r.status = ST_OK;
                end
            end
            REQ_READ: begin
                if (ix < fill) begin
                    r.read_id = neighbors[ix];
                    r.status  = ST_OK;
                end
            end
            default: begin
                // spare request codes change nothing
            end
        endcase
        r.link_count = LINK_W'(fill);
        return r;
    endfunction

    // track config writes, predict on each request word, check each reply word
    always @(posedge i_clk) begin : watch
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            own_id_q = '0;
            limit_q  = LIMIT_RESET;
            fill     = 0;
            awaited_replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OWN_ID:     own_id_q = i_cfg_data[OWN_ID_W-1:0];
                    CFG_LINK_LIMIT: limit_q  = i_cfg_data[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            // reply first: it always belongs to an older request
            if (i_rsp.valid && i_rsp.ready) begin
                got.status     = i_rsp.status;
                got.read_id    = i_rsp.read_id;
                got.link_count = i_rsp.link_count;
                if (awaited_replies.size() == 0) begin
                    $error("reply word with none awaited: status %0d read_id %0h count %0d",
                           got.status, got.read_id, got.link_count);
                    o_fail_count++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.read_id !== want.read_id) begin
                        $error("read_id: expected %0h, got %0h", want.read_id, got.read_id);
                        o_fail_count++;
                    end
                    if (got.link_count !== want.link_count) begin
                        $error("link_count: expected %0d, got %0d",
                               want.link_count, got.link_count);
                        o_fail_count++;
                    end
                end
            end
            // queue the reply this request word earns at the tail
            if (i_req.valid && i_req.ready) begin
                awaited_replies = {awaited_replies,
                                   serve_request(i_req.req_type, i_req.node_id,
                                                 i_req.index)};
            end
        end
        o_pending <= awaited_replies.size();
    end

endmodule

// ===== sim/testbench.sv =====
// top of the neighbor list bench: clock, reset, request and reply traffic, verdict
`timescale 1ns / 100ps

module testbench;
    import bnl_pkg::*;

    localparam t_req                  REQ_SPARE_FIRST = 3'd5;
    localparam t_req                  REQ_SPARE_LAST  = 3'd7;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE       = 2'd3;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 262;
    localparam int POOL        = 12;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_EVERY  = 700;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;
    logic [NODE_ID_W-1:0]  own_now;
    logic [NODE_ID_W-1:0]  id_pool [POOL];

    bnl_req_if req_bus ();
    bnl_rsp_if rsp_bus ();

    bounded_neighbor_list i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus)
    );

    neighbor_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // offer one request word and hold it until taken
    task automatic push_request(t_req kind, logic [NODE_ID_W-1:0] id,
                                logic [INDEX_W-1:0] ix);
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= kind;
        req_bus.node_id  <= id;
        req_bus.index    <= ix;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // one register write on the config port
    task automatic write_register(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // stop offering and wait for every owed reply
    task automatic wait_settled();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // reply side: stall pattern of its own plus occasional long hold-off
    initial begin : reply_side
        int taken;
        int holds_done;
        int hold_left;
        int mode_left;
        int ready_pct;
        taken      = 0;
        holds_done = 0;
        hold_left  = 0;
        mode_left  = 0;
        ready_pct  = 100;
        rsp_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_bus.valid && rsp_bus.ready) taken++;
            if (holds_done < 2 && taken >= HOLD_EVERY * (holds_done + 1)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    2: ready_pct = 40;
                    default: ready_pct = 15;
                endcase
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    // request side and verdict
    initial begin : request_side
        int                   own_plan [PHASES];
        logic [CFG_DATA_W-1:0] limit_plan [PHASES];
        int                   burst_left;
        int                   gap;
        int                   pick;
        t_req                 kind;
        logic [NODE_ID_W-1:0] id;

        own_plan   = '{0, -1, 32768, -1, -1, -1, 65535};
        // 31 acts as full capacity, 16'hFFE2 keeps only the low bits (limit 2)
        limit_plan = '{16'd16, 16'd0, 16'd31, 16'd1, 16'hFFE2, 16'd16, 16'd8};

        req_bus.valid    = 1'b0;
        req_bus.req_type = REQ_ADD;
        req_bus.node_id  = '0;
        req_bus.index    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_OWN_ID;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, add checks and their order, removals, spare codes
        own_now = 16'hFFFF;
        write_register(CFG_OWN_ID, own_now);
        write_register(CFG_LINK_LIMIT, 16'd3);
        i_cfg_we <= 1'b0;
        push_request(REQ_READ, 16'h0000, 4'd0);
        push_request(REQ_REMOVE_LAST, 16'h0000, 4'd0);
        push_request(REQ_REMOVE_AT, 16'h0000, 4'd0);
        push_request(REQ_REMOVE_ID, 16'h0000, 4'd0);
        push_request(REQ_ADD, 16'h0000, 4'd0);
        push_request(REQ_ADD, 16'hFFFF, 4'd15);
        push_request(REQ_ADD, 16'h0000, 4'd0);
        push_request(REQ_ADD, 16'h8001, 4'd0);
        push_request(REQ_ADD, 16'h7FFE, 4'd0);
        push_request(REQ_ADD, 16'h1234, 4'd0);
        push_request(REQ_ADD, 16'hFFFF, 4'd0);
        push_request(REQ_ADD, 16'h0000, 4'd0);
        push_request(REQ_READ, 16'h0000, 4'd15);
        push_request(REQ_READ, 16'h0000, 4'd2);
        push_request(REQ_REMOVE_AT, 16'h0000, 4'd3);
        push_request(REQ_REMOVE_ID, 16'h8001, 4'd0);
        push_request(REQ_READ, 16'hFFFF, 4'd1);
        push_request(REQ_SPARE_FIRST, 16'h0000, 4'd0);
        push_request(REQ_SPARE_LAST, 16'hFFFF, 4'd15);
        push_request(REQ_REMOVE_AT, 16'h0000, 4'd0);
        push_request(REQ_REMOVE_LAST, 16'h0000, 4'd0);
        push_request(REQ_REMOVE_LAST, 16'h0000, 4'd0);

        // random phases, each under its own own id and link limit
        for (int p = 0; p < PHASES; p++) begin
            wait_settled();
            own_now = (own_plan[p] < 0) ? NODE_ID_W'($urandom_range(0, 65535))
                                        : NODE_ID_W'(own_plan[p]);
            if (p == 4) write_register(CFG_SPARE, CFG_DATA_W'($urandom()));
            write_register(CFG_OWN_ID, own_now);
            write_register(CFG_LINK_LIMIT, limit_plan[p]);
            i_cfg_we <= 1'b0;
            foreach (id_pool[k]) id_pool[k] = NODE_ID_W'($urandom());
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        req_bus.valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
                burst_left--;
                // mostly pool ids so adds collide and removals hit
                pick = $urandom_range(0, 99);
                if (pick < 78) id = id_pool[$urandom_range(0, POOL - 1)];
                else if (pick < 84) id = own_now;
                else id = NODE_ID_W'($urandom());
                pick = $urandom_range(0, 99);
                if (pick < 38) kind = REQ_ADD;
                else if (pick < 50) kind = REQ_REMOVE_ID;
                else if (pick < 60) kind = REQ_REMOVE_AT;
                else if (pick < 68) kind = REQ_REMOVE_LAST;
                else if (pick < 95) kind = REQ_READ;
                else kind = t_req'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
                push_request(kind, id, INDEX_W'($urandom_range(0, 15)));
            end
        end

        // drain, let the block settle, then report
        wait_settled();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
